// ----- src/ctw_pkg.sv -----
// shared types and constants of the callout timer wheel
package ctw_pkg;

	localparam int TIMER_COUNT = 16;
	localparam int TIME_BITS   = 32;
	localparam int ORDER_BITS  = 32;
	localparam int ID_W        = $clog2(TIMER_COUNT);
	localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

	typedef logic [ID_W-1:0]       tid_t;
	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [ORDER_BITS-1:0] order_t;

	typedef struct packed {
		order_t order;
		time_t  expiry;
	} entry_t;

	typedef struct packed {
		logic   wr_en;
		tid_t   wr_addr;
		entry_t wr_data;
		logic   rd_en;
		tid_t   rd_addr;
	} mem_req_t;

	typedef enum logic [1:0] {
		OP_SCHED = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SCHED      = 2'd0,
		KIND_STOP       = 2'd1,
		KIND_FIRED      = 2'd2,
		KIND_IDLE_TICK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ----- src/ctw_mem.sv -----
// timer entry memory: one write port, one registered read port
module ctw_mem (
	input  logic              clk,
	input  ctw_pkg::mem_req_t req,
	output ctw_pkg::entry_t   rd_data
);

	ctw_pkg::entry_t mem [ctw_pkg::TIMER_COUNT];
	ctw_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/callout_timer_wheel.sv -----
// callout timer wheel top level: command channel, entry scan and result register
//
// a bank of one-shot timers. each slave-side transaction carries a command in
// s_axis_tuser: schedule, stop or tick. schedule and stop give one result,
// registered and shown in the cycle after the command transaction. a tick
// advances time and scans the entry memory: one pass reads every entry, one per
// cycle, and picks the oldest matching timer; then the emit state hands its
// fired result to the output register. a tick that fires n timers takes n
// passes, one pass if it fires none. a tick that fires nothing gives one result
// with kind nothing-fired. m_axis_tlast marks the final result of a command.
// the scan is bounded by the single read port of the entry memory.
// s_axis_tready is high only between commands and while the output register
// is empty or being emptied; a stall on the master side holds the result and
// the block waits. reset clears time, the schedule counter and all pending
// marks; the entry memory needs no clearing since a scan matches only
// pending timers.
module callout_timer_wheel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // timer_id[3:0], delay[19:4], zero pad
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // timer_id_res[3:0], was_pending[4], expiry_time[36:5]
	output logic [1:0]  m_axis_tuser,  // kind[1:0]
	output logic        m_axis_tlast
);

	ctw_pkg::state_t   state_q, state_d;
	ctw_pkg::op_t      in_op;
	ctw_pkg::mem_req_t mem_req;
	ctw_pkg::entry_t   rd_data;

	logic [3:0]                   in_id;
	logic [15:0]                  in_delay;
	logic [15:0]                  delay_eff;
	logic                         in_bank;
	ctw_pkg::tid_t                in_idx;
	ctw_pkg::time_t               sched_exp;
	ctw_pkg::time_t               time_q;
	ctw_pkg::order_t              order_q;
	logic [ctw_pkg::TIMER_COUNT-1:0] pending_q;
	logic [ctw_pkg::CNT_W-1:0]    cnt_q;
	logic                         rd_vld_s1;
	ctw_pkg::tid_t                idx_s1;
	logic                         found_q;
	logic                         multi_q;
	ctw_pkg::tid_t                best_id_q;
	ctw_pkg::order_t              best_age_q;
	ctw_pkg::order_t              age;
	logic                         match;
	logic                         accept;
	logic                         out_free;
	logic                         rd_en;

	logic                         load;
	ctw_pkg::kind_t               ld_kind;
	logic [3:0]                   ld_id;
	logic                         ld_pend;
	logic [31:0]                  ld_exp;
	logic                         ld_last;

	logic                         out_valid_q;
	ctw_pkg::kind_t               out_kind_q;
	logic [3:0]                   out_id_q;
	logic                         out_pend_q;
	logic [31:0]                  out_exp_q;
	logic                         out_last_q;

	assign in_op     = ctw_pkg::op_t'(s_axis_tuser);
	assign in_id     = s_axis_tdata[3:0];
	assign in_delay  = s_axis_tdata[19:4];
	assign delay_eff = (in_delay == 16'd0) ? 16'd1 : in_delay;
	assign in_bank   = int'(in_id) < ctw_pkg::TIMER_COUNT;
	assign in_idx    = ctw_pkg::ID_W'(in_id);
	assign sched_exp = time_q + ctw_pkg::TIME_BITS'(delay_eff);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign rd_en     = (state_q == ctw_pkg::ST_SCAN) &&
		(cnt_q < ctw_pkg::CNT_W'(ctw_pkg::TIMER_COUNT));

	assign age   = order_q - rd_data.order;
	assign match = rd_vld_s1 && pending_q[idx_s1] && (rd_data.expiry == time_q);

	always_comb begin
		mem_req.wr_en   = accept && (in_op == ctw_pkg::OP_SCHED) && in_bank;
		mem_req.wr_addr = in_idx;
		mem_req.wr_data = '{order: order_q, expiry: sched_exp};
		mem_req.rd_en   = rd_en;
		mem_req.rd_addr = cnt_q[ctw_pkg::ID_W-1:0];
	end

	ctw_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load          = 1'b0;
		ld_kind       = ctw_pkg::KIND_SCHED;
		ld_id         = 4'd0;
		ld_pend       = 1'b0;
		ld_exp        = 32'd0;
		ld_last       = 1'b1;
		case (state_q)
			ctw_pkg::ST_IDLE: begin
				s_axis_tready = out_free;
				if (s_axis_tvalid && out_free) begin
					case (in_op)
						ctw_pkg::OP_SCHED: begin
							load    = 1'b1;
							ld_kind = ctw_pkg::KIND_SCHED;
							ld_id   = in_id;
							ld_pend = in_bank && pending_q[in_idx];
							ld_exp  = 32'(sched_exp);
						end
						ctw_pkg::OP_STOP: begin
							load    = 1'b1;
							ld_kind = ctw_pkg::KIND_STOP;
							ld_id   = in_id;
							ld_pend = in_bank && pending_q[in_idx];
						end
						ctw_pkg::OP_TICK: begin
							state_d = ctw_pkg::ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ctw_pkg::ST_SCAN: begin
				if (!rd_en && !rd_vld_s1) begin
					state_d = ctw_pkg::ST_EMIT;
				end
			end
			ctw_pkg::ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (found_q) begin
						ld_kind = ctw_pkg::KIND_FIRED;
						ld_id   = 4'(best_id_q);
						ld_exp  = 32'(time_q);
						ld_last = !multi_q;
						state_d = multi_q ? ctw_pkg::ST_SCAN : ctw_pkg::ST_IDLE;
					end else begin
						ld_kind = ctw_pkg::KIND_IDLE_TICK;
						state_d = ctw_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ctw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			order_q   <= '0;
			pending_q <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			multi_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + ctw_pkg::CNT_W'(1);
			end
			if (accept) begin
				case (in_op)
					ctw_pkg::OP_SCHED: begin
						if (in_bank) begin
							pending_q[in_idx] <= 1'b1;
							order_q           <= order_q + ctw_pkg::ORDER_BITS'(1);
						end
					end
					ctw_pkg::OP_STOP: begin
						if (in_bank) begin
							pending_q[in_idx] <= 1'b0;
						end
					end
					ctw_pkg::OP_TICK: begin
						time_q  <= time_q + ctw_pkg::TIME_BITS'(1);
						cnt_q   <= '0;
						found_q <= 1'b0;
						multi_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (match) begin
				found_q <= 1'b1;
				if (found_q) begin
					multi_q <= 1'b1;
				end
			end
			if ((state_q == ctw_pkg::ST_EMIT) && load && found_q) begin
				pending_q[best_id_q] <= 1'b0;
				if (multi_q) begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					multi_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[ctw_pkg::ID_W-1:0];
		if (match && (!found_q || (age > best_age_q))) begin
			best_id_q  <= idx_s1;
			best_age_q <= age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= ld_kind;
			out_id_q   <= ld_id;
			out_pend_q <= ld_pend;
			out_exp_q  <= ld_exp;
			out_last_q <= ld_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_exp_q, out_pend_q, out_id_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctw_pkg::ST_EMIT) && found_q |-> pending_q[best_id_q])
		else $error("timer to fire is not pending");

	a_multi_found: assert property (@(posedge clk) disable iff (!arst_n)
		multi_q |-> found_q)
		else $error("several matches flagged without a match");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ctw_pkg::CNT_W'(ctw_pkg::TIMER_COUNT))
		else $error("scan counter out of range");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !rd_vld_s1 && !rd_en)
		else $error("command taken during a scan");

endmodule

// ----- tb/ctw_checker.sv -----
// checker for the callout timer wheel: command tracking, result prediction and comparison
module ctw_checker
	import ctw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t kind;
		tid_t  timer_id;
		logic  was_pending;
		time_t expiry_time;
		logic  last;
	} timer_result_t;

	logic          armed [TIMER_COUNT];
	time_t         expiry [TIMER_COUNT];
	order_t        sched_order [TIMER_COUNT];
	time_t         now;
	order_t        sched_count;
	timer_result_t due_results [$];

	function automatic timer_result_t make_result(kind_t kind, tid_t id, logic pend,
			time_t exp_time, logic last);
		timer_result_t r;
		r.kind        = kind;
		r.timer_id    = id;
		r.was_pending = pend;
		r.expiry_time = exp_time;
		r.last        = last;
		return r;
	endfunction

	// updates the timer bank for one command and queues the results it causes
	task automatic predict_command(input op_t op, input tid_t id, input logic [15:0] delay);
		time_t  due;
		order_t age;
		int     fire_list [TIMER_COUNT];
		int     n;
		int     j;
		n = 0;
		case (op)
			OP_SCHED: begin
				due = now + time_t'((delay == 16'd0) ? 16'd1 : delay);
				due_results.push_back(make_result(KIND_SCHED, id, armed[id], due, 1'b1));
				armed[id]       = 1'b1;
				expiry[id]      = due;
				sched_order[id] = sched_count;
				sched_count     = sched_count + 1;
			end
			OP_STOP: begin
				due_results.push_back(make_result(KIND_STOP, id, armed[id], '0, 1'b1));
				armed[id] = 1'b0;
			end
			OP_TICK: begin
				now = now + 1;
				// oldest schedule first, ties to the lower id
				for (int i = 0; i < TIMER_COUNT; i++) begin
					if (armed[i] && expiry[i] == now) begin
						age = sched_count - sched_order[i];
						j = n;
						while (j > 0 && order_t'(sched_count - sched_order[fire_list[j-1]]) < age) begin
							fire_list[j] = fire_list[j-1];
							j--;
						end
						fire_list[j] = i;
						n++;
					end
				end
				if (n == 0) begin
					due_results.push_back(make_result(KIND_IDLE_TICK, '0, 1'b0, '0, 1'b1));
				end else begin
					for (int k = 0; k < n; k++) begin
						armed[fire_list[k]] = 1'b0;
						due_results.push_back(make_result(KIND_FIRED, tid_t'(fire_list[k]), 1'b0,
							expiry[fire_list[k]], k == n - 1));
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				armed[i]       = 1'b0;
				expiry[i]      = '0;
				sched_order[i] = '0;
			end
			now         = '0;
			sched_count = '0;
			due_results.delete();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_command(op_t'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[19:4]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d timer %0d", m_axis_tuser, m_axis_tdata[3:0]);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", want.kind, m_axis_tuser);
					check_field("timer_id_res", want.timer_id, m_axis_tdata[3:0]);
					check_field("was_pending", want.was_pending, m_axis_tdata[4]);
					check_field("expiry_time", want.expiry_time, m_axis_tdata[36:5]);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ----- tb/tb_callout_timer_wheel.sv -----
// testbench top for the callout timer wheel: clock, reset, command stimulus and verdict
module tb_callout_timer_wheel;
	timeunit 1ns;
	timeprecision 1ps;
	import ctw_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 4;
	localparam int RANDOM_ITEMS   = 260;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT     = 4000;
	localparam int SETTLE_CYCLES  = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fail_count;
	int outstanding;
	int commands_sent = 0;
	int stall_cycles = 0;
	bit fast_tx = 1'b0;
	bit fast_rx = 1'b0;
	bit hold_req = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	callout_timer_wheel dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.m_axis_tlast
	);

	ctw_checker chk (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.m_axis_tlast,
		.fail_count,
		.outstanding
	);

	task automatic send_cmd(input op_t op, input tid_t id, input logic [15:0] delay);
		int gap;
		gap = fast_tx ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, delay, id};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
		if (op != OP_NONE)
			commands_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_cmd(OP_TICK, '0, 16'($urandom));
	endtask

	// every timer armed with one delay in shuffled order, then ticked until they all fire
	task automatic arm_whole_bank(input logic [15:0] delay);
		int ids [TIMER_COUNT];
		int k;
		int tmp;
		for (int i = 0; i < TIMER_COUNT; i++)
			ids[i] = i;
		for (int i = TIMER_COUNT - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = ids[i];
			ids[i] = ids[k];
			ids[k] = tmp;
		end
		for (int i = 0; i < TIMER_COUNT; i++)
			send_cmd(OP_SCHED, tid_t'(ids[i]), delay);
		send_ticks((delay == 16'd0) ? 1 : delay);
	endtask

	task automatic run_burst();
		int          count;
		logic [15:0] base;
		count = $urandom_range(1, 6);
		base  = 16'($urandom_range(0, 4));
		repeat (count)
			send_cmd(OP_SCHED, tid_t'($urandom_range(0, 15)),
				$urandom_range(0, 1) ? base : 16'($urandom_range(0, 5)));
		if ($urandom_range(0, 2) == 0)
			send_cmd(OP_STOP, tid_t'($urandom_range(0, 15)), 16'($urandom));
		send_ticks($urandom_range(1, 7));
	endtask

	task automatic send_random_command();
		int          pick;
		int          span;
		op_t         op;
		logic [15:0] delay;
		pick = $urandom_range(0, 19);
		span = $urandom_range(0, 9);
		if (pick == 0)
			op = OP_NONE;
		else if (pick <= 8)
			op = OP_SCHED;
		else if (pick <= 12)
			op = OP_STOP;
		else
			op = OP_TICK;
		if (span < 7)
			delay = 16'($urandom_range(0, 6));
		else if (span < 9)
			delay = 16'($urandom_range(0, 300));
		else
			delay = 16'($urandom_range(0, 65535));
		send_cmd(op, tid_t'($urandom_range(0, 15)), delay);
	endtask

	// result side: random stalls, runs without stalls, and one long hold-off on request
	initial begin
		int gap;
		bit took;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !held) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end else begin
				gap = fast_rx ? 0 : $urandom_range(0, 11);
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
				took = m_axis_tvalid && m_axis_tready;
				@(negedge clk);
			end while (!took && !(hold_req && !held));
			if ($urandom_range(0, 19) == 0)
				fast_rx = ~fast_rx;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == IDLE_LIMIT) begin
			$display("callout_timer_wheel test failed");
			$finish;
		end
	end

	initial begin
		int pick;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle tick, shortest delay, stops, longest delay and re-arm, unused op
		send_cmd(OP_TICK, 4'd0, 16'd0);
		send_cmd(OP_SCHED, 4'd0, 16'd0);
		send_cmd(OP_TICK, 4'd0, 16'd0);
		send_cmd(OP_STOP, 4'd0, 16'd0);
		send_cmd(OP_STOP, 4'd15, 16'hffff);
		send_cmd(OP_SCHED, 4'd15, 16'hffff);
		send_cmd(OP_SCHED, 4'd15, 16'd2);
		send_cmd(OP_STOP, 4'd15, 16'd0);
		send_cmd(OP_NONE, 4'd9, 16'h5a5a);
		// re-armed timer drops behind one scheduled later
		send_cmd(OP_SCHED, 4'd3, 16'd3);
		send_cmd(OP_SCHED, 4'd7, 16'd2);
		send_cmd(OP_SCHED, 4'd3, 16'd2);
		send_ticks(2);
		send_cmd(OP_SCHED, 4'd10, 16'hffff);
		wait_drained();

		// output held off while a full bank is armed and fired
		hold_req = 1'b1;
		arm_whole_bank(16'd1);
		wait_drained();

		while (commands_sent < RANDOM_ITEMS) begin
			fast_tx = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 12)
				run_burst();
			else if (pick < 18)
				send_random_command();
			else if (pick == 18)
				arm_whole_bank(16'($urandom_range(0, 3)));
			else
				wait_drained();
		end

		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("callout_timer_wheel test passed");
		else
			$display("callout_timer_wheel test failed");
		$finish;
	end

endmodule
